[sv/bpe_pkg.sv]
package bpe_pkg;

    // IEEE binary64 constants used by the energy expression
    localparam logic [63:0] C_0P07     = 64'h3FB1_EB85_1EB8_51EC;
    localparam logic [63:0] C_1P07     = 64'h3FF1_1EB8_51EB_851F;
    localparam logic [63:0] C_0P12     = 64'h3FBE_B851_EB85_1EB8;
    localparam logic [63:0] C_1P12     = 64'h3FF1_EB85_1EB8_51EC;
    localparam logic [63:0] C_MINUS2   = 64'hC000_0000_0000_0000;
    localparam logic [63:0] C_POS_ZERO = 64'h0000_0000_0000_0000;

    localparam int unsigned STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_FIRST = 5'd0;
    localparam logic [STEP_W-1:0] STEP_TOTAL = 5'd17;

    typedef enum logic [1:0] {
        FOP_ADD,
        FOP_MUL,
        FOP_DIV
    } fop_t;

    // operand and destination selectors of the datapath
    typedef enum logic [3:0] {
        OPD_R,
        OPD_S,
        OPD_EPS,
        OPD_Q,
        OPD_X,
        OPD_Y,
        OPD_A,
        OPD_E,
        OPD_SUM,
        OPD_T,
        OPD_C007,
        OPD_C107,
        OPD_C012,
        OPD_C112,
        OPD_CM2,
        OPD_ZERO
    } opnd_t;

    typedef struct packed {
        fop_t  op;
        opnd_t src_a;
        opnd_t src_b;
        opnd_t dst;
    } uop_t;

    typedef struct packed {
        logic load_in;
        logic load_e_stored;
        logic load_e_zero;
        logic fpu_start;
        uop_t uop;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic fpu_done;
        logic recalc;
        logic skip;
    } dp_status_t;

    typedef enum logic [2:0] {
        CT_IDLE,
        CT_CHECK,
        CT_ISSUE,
        CT_WAIT,
        CT_OUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_ADD,
        F_MUL,
        F_PRENORM,
        F_DIV,
        F_NORM
    } fpu_state_t;

    // operation sequence for one recomputed pair, then the running total
    function automatic uop_t ucode(input logic [STEP_W-1:0] step);
        uop_t u;
        case (step)
            5'd0:  u = '{FOP_DIV, OPD_R,    OPD_S,    OPD_Q};
            5'd1:  u = '{FOP_ADD, OPD_Q,    OPD_C007, OPD_X};
            5'd2:  u = '{FOP_DIV, OPD_C107, OPD_X,    OPD_A};
            5'd3:  u = '{FOP_MUL, OPD_A,    OPD_A,    OPD_X};
            5'd4:  u = '{FOP_MUL, OPD_X,    OPD_A,    OPD_Y};
            5'd5:  u = '{FOP_MUL, OPD_Y,    OPD_Y,    OPD_Y};
            5'd6:  u = '{FOP_MUL, OPD_Y,    OPD_A,    OPD_A};
            5'd7:  u = '{FOP_MUL, OPD_Q,    OPD_Q,    OPD_X};
            5'd8:  u = '{FOP_MUL, OPD_X,    OPD_Q,    OPD_Y};
            5'd9:  u = '{FOP_MUL, OPD_Y,    OPD_Y,    OPD_Y};
            5'd10: u = '{FOP_MUL, OPD_Y,    OPD_Q,    OPD_Q};
            5'd11: u = '{FOP_ADD, OPD_Q,    OPD_C012, OPD_X};
            5'd12: u = '{FOP_DIV, OPD_C112, OPD_X,    OPD_X};
            5'd13: u = '{FOP_ADD, OPD_X,    OPD_CM2,  OPD_X};
            5'd14: u = '{FOP_MUL, OPD_EPS,  OPD_A,    OPD_Y};
            5'd15: u = '{FOP_MUL, OPD_Y,    OPD_X,    OPD_Y};
            5'd16: u = '{FOP_ADD, OPD_ZERO, OPD_Y,    OPD_E};
            default: u = '{FOP_ADD, OPD_SUM, OPD_E,   OPD_T};
        endcase
        return u;
    endfunction

endpackage

[sv/bpe_fpu.sv]
module bpe_fpu import bpe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  fop_t        op,
    input  logic [63:0] opa,
    input  logic [63:0] opb,
    output logic        done,
    output logic [63:0] result
);

    localparam logic [63:0] NAN_DEFAULT = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] NAN_DIVZERO = 64'h7FF8_0000_0000_0000;

    fpu_state_t st_reg, st_next;
    logic done_reg, done_next;
    logic [63:0] res_reg;
    logic sign_reg, sub_reg;
    logic signed [13:0] exp_reg, xa_reg, xb_reg;
    logic [52:0] ma_reg, mb_reg;
    logic [111:0] man_reg;
    logic [54:0] rem_reg;
    logic [54:0] quo_reg;
    logic [5:0] cnt_reg;

    // round a normalized magnitude to binary64, nearest even
    function automatic logic [63:0] round_pack(input logic sgn,
                                               input logic signed [13:0] ex,
                                               input logic [111:0] mn);
        logic signed [13:0] be;
        logic [13:0] sh;
        logic [5:0] s;
        logic [111:0] shf;
        logic stk;
        logic [10:0] fld;
        logic inc;
        logic [63:0] res;
        be = ex + 14'sd1134;
        sh = 14'(14'sd1 - be);
        s = '0;
        fld = '0;
        res = '0;
        if (be >= 14'sd2047) begin
            res = {sgn, 11'h7FF, 52'b0};
        end else begin
            if (be <= 14'sd0) begin
                s = (sh > 14'd63) ? 6'd63 : sh[5:0];
            end else begin
                fld = be[10:0];
            end
            shf = mn >> s;
            stk = |(mn & ~({112{1'b1}} << s));
            inc = shf[58] & ((|shf[57:0]) | stk | shf[59]);
            res = {sgn, fld, shf[110:59]} + {63'b0, inc};
        end
        return res;
    endfunction

    // unpack operands
    logic [10:0] ea, eb;
    logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sx;
    logic signed [13:0] xa_in, xb_in;
    logic [52:0] ma_in, mb_in;

    assign ea     = opa[62:52];
    assign eb     = opb[62:52];
    assign a_nan  = (&ea) & (|opa[51:0]);
    assign b_nan  = (&eb) & (|opb[51:0]);
    assign a_inf  = (&ea) & ~(|opa[51:0]);
    assign b_inf  = (&eb) & ~(|opb[51:0]);
    assign a_zero = ~(|opa[62:0]);
    assign b_zero = ~(|opb[62:0]);
    assign sx     = opa[63] ^ opb[63];
    assign xa_in  = (ea == 11'd0) ? 14'sd1 : $signed({3'b0, ea});
    assign xb_in  = (eb == 11'd0) ? 14'sd1 : $signed({3'b0, eb});
    assign ma_in  = {|ea, opa[51:0]};
    assign mb_in  = {|eb, opb[51:0]};

    // resolve NaN, infinity and zero operands up front
    logic spec;
    logic [63:0] spec_val;
    always_comb begin
        spec = 1'b1;
        spec_val = '0;
        if (op == FOP_DIV && b_zero) begin
            spec_val = (a_zero | a_nan) ? NAN_DIVZERO : {sx, 11'h7FF, 52'b0};
        end else if (a_nan) begin
            spec_val = opa | 64'h0008_0000_0000_0000;
        end else if (b_nan) begin
            spec_val = opb | 64'h0008_0000_0000_0000;
        end else begin
            case (op)
                FOP_ADD: begin
                    if (a_inf && b_inf && (opa[63] != opb[63])) spec_val = NAN_DEFAULT;
                    else if (a_inf) spec_val = opa;
                    else if (b_inf) spec_val = opb;
                    else if (a_zero && b_zero) spec_val = {opa[63] & opb[63], 63'b0};
                    else if (a_zero) spec_val = opb;
                    else if (b_zero) spec_val = opa;
                    else spec = 1'b0;
                end
                FOP_MUL: begin
                    if ((a_inf && b_zero) || (a_zero && b_inf)) spec_val = NAN_DEFAULT;
                    else if (a_inf || b_inf) spec_val = {sx, 11'h7FF, 52'b0};
                    else if (a_zero || b_zero) spec_val = {sx, 63'b0};
                    else spec = 1'b0;
                end
                FOP_DIV: begin
                    if (a_inf && b_inf) spec_val = NAN_DEFAULT;
                    else if (a_inf) spec_val = {sx, 11'h7FF, 52'b0};
                    else if (b_inf || a_zero) spec_val = {sx, 63'b0};
                    else spec = 1'b0;
                end
                default: spec_val = NAN_DEFAULT;
            endcase
        end
    end

    // align and add or subtract
    logic signed [13:0] add_d;
    logic [111:0] add_big, add_small, add_al, add_sum;
    logic add_stk;
    always_comb begin
        add_d = xa_reg - xb_reg;
        add_big = {1'b0, ma_reg, 58'b0};
        add_small = {1'b0, mb_reg, 58'b0};
        if (add_d >= 14'sd112) begin
            add_al = '0;
            add_stk = |mb_reg;
        end else begin
            add_al = add_small >> add_d[6:0];
            add_stk = |(add_small & ~({112{1'b1}} << add_d[6:0]));
        end
        add_al = add_al | {111'b0, add_stk};
        add_sum = sub_reg ? (add_big - add_al) : (add_big + add_al);
    end

    // one 27x27 partial product per cycle
    logic [26:0] mul_x, mul_y;
    logic [53:0] mul_pp;
    logic [111:0] mul_sh;
    always_comb begin
        case (cnt_reg[1:0])
            2'd0: begin
                mul_x = ma_reg[26:0];
                mul_y = mb_reg[26:0];
            end
            2'd1: begin
                mul_x = ma_reg[26:0];
                mul_y = {1'b0, mb_reg[52:27]};
            end
            2'd2: begin
                mul_x = {1'b0, ma_reg[52:27]};
                mul_y = mb_reg[26:0];
            end
            default: begin
                mul_x = {1'b0, ma_reg[52:27]};
                mul_y = {1'b0, mb_reg[52:27]};
            end
        endcase
        mul_pp = mul_x * mul_y;
        case (cnt_reg[1:0])
            2'd0:    mul_sh = {58'b0, mul_pp};
            2'd3:    mul_sh = {4'b0, mul_pp, 54'b0};
            default: mul_sh = {31'b0, mul_pp, 27'b0};
        endcase
    end

    // one quotient bit per cycle
    logic div_ge;
    logic [54:0] div_diff;
    assign div_ge   = rem_reg >= {2'b0, mb_reg};
    assign div_diff = div_ge ? (rem_reg - {2'b0, mb_reg}) : rem_reg;

    // next state
    always_comb begin
        st_next = st_reg;
        done_next = 1'b0;
        case (st_reg)
            F_IDLE: begin
                if (start) begin
                    if (spec) begin
                        done_next = 1'b1;
                    end else begin
                        case (op)
                            FOP_ADD: st_next = F_ADD;
                            FOP_MUL: st_next = F_MUL;
                            default: st_next = F_PRENORM;
                        endcase
                    end
                end
            end
            F_ADD: st_next = F_NORM;
            F_MUL: if (cnt_reg == 6'd3) st_next = F_NORM;
            F_PRENORM: if (ma_reg[52] && mb_reg[52]) st_next = F_DIV;
            F_DIV: if (cnt_reg == 6'd55) st_next = F_NORM;
            F_NORM: begin
                if (man_reg == '0 || man_reg[111]) begin
                    st_next = F_IDLE;
                    done_next = 1'b1;
                end
            end
            default: st_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= F_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            done_reg <= done_next;
        end
    end

    // datapath registers of the unit
    always_ff @(posedge aclk) begin
        case (st_reg)
            F_IDLE: begin
                if (start) begin
                    res_reg <= spec_val;
                    cnt_reg <= '0;
                    man_reg <= '0;
                    quo_reg <= '0;
                    if (op == FOP_ADD) begin
                        sub_reg <= sx;
                        if (opb[62:0] > opa[62:0]) begin
                            sign_reg <= opb[63];
                            ma_reg <= mb_in;
                            xa_reg <= xb_in;
                            mb_reg <= ma_in;
                            xb_reg <= xa_in;
                        end else begin
                            sign_reg <= opa[63];
                            ma_reg <= ma_in;
                            xa_reg <= xa_in;
                            mb_reg <= mb_in;
                            xb_reg <= xb_in;
                        end
                    end else begin
                        sub_reg <= 1'b0;
                        sign_reg <= sx;
                        ma_reg <= ma_in;
                        mb_reg <= mb_in;
                        xa_reg <= xa_in;
                        xb_reg <= xb_in;
                        exp_reg <= xa_in + xb_in - 14'sd2150;
                    end
                end
            end
            F_ADD: begin
                man_reg <= add_sum;
                exp_reg <= xa_reg - 14'sd1133;
                if (add_sum == '0) sign_reg <= 1'b0;
            end
            F_MUL: begin
                man_reg <= man_reg + mul_sh;
                cnt_reg <= cnt_reg + 6'd1;
            end
            F_PRENORM: begin
                if (!ma_reg[52]) begin
                    ma_reg <= {ma_reg[51:0], 1'b0};
                    xa_reg <= xa_reg - 14'sd1;
                end else if (!mb_reg[52]) begin
                    mb_reg <= {mb_reg[51:0], 1'b0};
                    xb_reg <= xb_reg - 14'sd1;
                end else begin
                    rem_reg <= {2'b0, ma_reg};
                    exp_reg <= xa_reg - xb_reg - 14'sd111;
                end
            end
            F_DIV: begin
                rem_reg <= {div_diff[53:0], 1'b0};
                quo_reg <= {quo_reg[53:0], div_ge};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd55) begin
                    man_reg <= {quo_reg, div_ge, 55'b0, |div_diff};
                end
            end
            F_NORM: begin
                if (man_reg == '0) begin
                    res_reg <= {sign_reg, 63'b0};
                end else if (man_reg[111:96] == 16'd0) begin
                    man_reg <= {man_reg[95:0], 16'b0};
                    exp_reg <= exp_reg - 14'sd16;
                end else if (!man_reg[111]) begin
                    man_reg <= {man_reg[110:0], 1'b0};
                    exp_reg <= exp_reg - 14'sd1;
                end else begin
                    res_reg <= round_pack(sign_reg, exp_reg, man_reg);
                end
            end
            default: begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

[sv/bpe_datapath.sv]
module bpe_datapath import bpe_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [63:0]  cfg_wdata,
    input  logic [255:0] in_data,
    input  logic [2:0]   in_flags,
    input  logic         in_last,
    input  dp_cmd_t      cmd,
    output dp_status_t   status,
    output logic [63:0]  pair_energy,
    output logic [63:0]  total_energy,
    output logic         total_done
);

    logic [63:0] cutoff_reg, sum_reg;
    logic [63:0] r_reg, s_reg, eps_reg, stored_reg;
    logic [63:0] q_reg, x_reg, y_reg, a_reg, e_reg, t_reg;
    logic recalc_reg, excl_reg, froz_reg, last_reg;
    opnd_t dst_reg;

    logic fpu_done;
    logic [63:0] fpu_res, opa, opb;

    function automatic logic [63:0] pick(input opnd_t sel, input logic [63:0] r,
                                         input logic [63:0] s, input logic [63:0] eps,
                                         input logic [63:0] q, input logic [63:0] x,
                                         input logic [63:0] y, input logic [63:0] a,
                                         input logic [63:0] e, input logic [63:0] sum,
                                         input logic [63:0] t);
        logic [63:0] v;
        case (sel)
            OPD_R:    v = r;
            OPD_S:    v = s;
            OPD_EPS:  v = eps;
            OPD_Q:    v = q;
            OPD_X:    v = x;
            OPD_Y:    v = y;
            OPD_A:    v = a;
            OPD_E:    v = e;
            OPD_SUM:  v = sum;
            OPD_T:    v = t;
            OPD_C007: v = C_0P07;
            OPD_C107: v = C_1P07;
            OPD_C012: v = C_0P12;
            OPD_C112: v = C_1P12;
            OPD_CM2:  v = C_MINUS2;
            default:  v = C_POS_ZERO;
        endcase
        return v;
    endfunction

    // select operands for the shared unit
    assign opa = pick(cmd.uop.src_a, r_reg, s_reg, eps_reg, q_reg, x_reg, y_reg, a_reg,
                      e_reg, sum_reg, t_reg);
    assign opb = pick(cmd.uop.src_b, r_reg, s_reg, eps_reg, q_reg, x_reg, y_reg, a_reg,
                      e_reg, sum_reg, t_reg);

    bpe_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.fpu_start),
        .op      (cmd.uop.op),
        .opa     (opa),
        .opb     (opb),
        .done    (fpu_done),
        .result  (fpu_res)
    );

    // cutoff test: r strictly above the cutoff, NaN on either side fails
    logic r_nan, c_nan, both_zero, r_gt;
    always_comb begin
        r_nan = (&r_reg[62:52]) & (|r_reg[51:0]);
        c_nan = (&cutoff_reg[62:52]) & (|cutoff_reg[51:0]);
        both_zero = ~(|r_reg[62:0]) & ~(|cutoff_reg[62:0]);
        if (r_nan || c_nan || both_zero) r_gt = 1'b0;
        else if (r_reg[63] != cutoff_reg[63]) r_gt = ~r_reg[63];
        else if (!r_reg[63]) r_gt = r_reg[62:0] > cutoff_reg[62:0];
        else r_gt = r_reg[62:0] < cutoff_reg[62:0];
    end

    assign status.fpu_done = fpu_done;
    assign status.recalc   = recalc_reg;
    assign status.skip     = r_gt | excl_reg | froz_reg;

    // configuration and running sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg <= '0;
            sum_reg <= C_POS_ZERO;
        end else begin
            if (cfg_we) cutoff_reg <= cfg_wdata;
            if (cmd.commit) sum_reg <= last_reg ? C_POS_ZERO : t_reg;
        end
    end

    // capture the beat and write back unit results
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            r_reg      <= in_data[63:0];
            s_reg      <= in_data[127:64];
            eps_reg    <= in_data[191:128];
            stored_reg <= in_data[255:192];
            recalc_reg <= in_flags[0];
            excl_reg   <= in_flags[1];
            froz_reg   <= in_flags[2];
            last_reg   <= in_last;
        end
        if (cmd.load_e_stored) e_reg <= stored_reg;
        if (cmd.load_e_zero) e_reg <= C_POS_ZERO;
        if (cmd.fpu_start) dst_reg <= cmd.uop.dst;
        if (fpu_done) begin
            case (dst_reg)
                OPD_Q:   q_reg <= fpu_res;
                OPD_X:   x_reg <= fpu_res;
                OPD_Y:   y_reg <= fpu_res;
                OPD_A:   a_reg <= fpu_res;
                OPD_E:   e_reg <= fpu_res;
                OPD_T:   t_reg <= fpu_res;
                default: t_reg <= fpu_res;
            endcase
        end
    end

    assign pair_energy  = e_reg;
    assign total_energy = t_reg;
    assign total_done   = last_reg;

endmodule

[sv/bpe_ctrl.sv]
module bpe_ctrl import bpe_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic       out_free,
    input  dp_status_t status,
    output logic       in_ready,
    output dp_cmd_t    cmd
);

    ctrl_state_t st_reg, st_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // next state
    always_comb begin
        st_next = st_reg;
        step_next = step_reg;
        case (st_reg)
            CT_IDLE: if (in_valid) st_next = CT_CHECK;
            CT_CHECK: begin
                st_next = CT_ISSUE;
                step_next = (status.recalc && !status.skip) ? STEP_FIRST : STEP_TOTAL;
            end
            CT_ISSUE: st_next = CT_WAIT;
            CT_WAIT: begin
                if (status.fpu_done) begin
                    if (step_reg == STEP_TOTAL) begin
                        st_next = CT_OUT;
                    end else begin
                        st_next = CT_ISSUE;
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            CT_OUT: if (out_free) st_next = CT_IDLE;
            default: st_next = CT_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd = '0;
        cmd.uop = ucode(step_reg);
        in_ready = 1'b0;
        case (st_reg)
            CT_IDLE: begin
                in_ready = 1'b1;
                cmd.load_in = in_valid;
            end
            CT_CHECK: begin
                cmd.load_e_stored = ~status.recalc;
                cmd.load_e_zero = status.recalc & status.skip;
            end
            CT_ISSUE: cmd.fpu_start = 1'b1;
            CT_OUT: cmd.commit = out_free;
            default: cmd.commit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= CT_IDLE;
            step_reg <= STEP_FIRST;
        end else begin
            st_reg <= st_next;
            step_reg <= step_next;
        end
    end

endmodule

[sv/buffered_14_7_pair_energy_unit.sv]
// A reused or zeroed pair needs only one add for the total; a recomputed pair is bound
// by the single shared double unit (three divisions, ten multiplies, five adds, plus
// normalization).
// Throughput: one pair at a time; the next beat is taken while the result waits.
// Reset (aresetn low, synchronous): running sum to +0.0, cutoff to +0.0, no result.
module buffered_14_7_pair_energy_unit import bpe_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [63:0]  cfg_wdata,     // cutoff_radius
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // distance, sigma_value, epsilon_value, stored_energy
    input  logic [255:0] s_axis_tdata,
    // recalculate, excluded, frozen_pair
    input  logic [2:0]   s_axis_tuser,
    input  logic         s_axis_tlast,  // last_pair
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pair_energy, total_energy
    output logic [127:0] m_axis_tdata,
    output logic         m_axis_tlast   // total_done
);

    dp_cmd_t cmd;
    dp_status_t status;
    logic out_free;
    logic [63:0] pair_energy, total_energy;
    logic total_done;
    logic m_valid_reg;
    logic [127:0] m_data_reg;
    logic m_last_reg;

    assign out_free = ~m_valid_reg | m_axis_tready;

    bpe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .status   (status),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    bpe_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_data      (s_axis_tdata),
        .in_flags     (s_axis_tuser),
        .in_last      (s_axis_tlast),
        .cmd          (cmd),
        .status       (status),
        .pair_energy  (pair_energy),
        .total_energy (total_energy),
        .total_done   (total_done)
    );

    // hold the result beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_data_reg <= {total_energy, pair_energy};
            m_last_reg <= total_done;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

[sim/pair_energy_checker.sv]
module pair_energy_checker import bpe_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,
    input  logic [2:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [127:0] m_axis_tdata,
    input  logic         m_axis_tlast,
    output int           fail_count,
    output int           pending
);

    typedef struct {
        logic [63:0] pair_energy;
        logic [63:0] total_energy;
        logic        total_done;
    } energy_result_t;

    energy_result_t energy_queue[$];
    logic [63:0]    cutoff_bits;
    real            running_sum;

    // IEEE division with the explicit zero-divisor results
    function automatic real ieee_div(real n, real d);
        logic [63:0] nb, db;
        nb = $realtobits(n);
        db = $realtobits(d);
        if (d == 0.0) begin
            if (n == 0.0 || n != n)
                return $bitstoreal(64'h7FF8_0000_0000_0000);
            return $bitstoreal({nb[63] ^ db[63], 11'h7FF, 52'h0});
        end
        return n / d;
    endfunction

    // seventh power, every partial product rounded
    function automatic real seventh_power(real x);
        real x2, x3, x6;
        x2 = x * x;
        x3 = x2 * x;
        x6 = x3 * x3;
        return x6 * x;
    endfunction

    function automatic real buffered_14_7(real r, real s, real eps);
        real q, a, b, p;
        q = ieee_div(r, s);
        a = ieee_div($bitstoreal(C_1P07), q + $bitstoreal(C_0P07));
        b = ieee_div($bitstoreal(C_1P12), seventh_power(q) + $bitstoreal(C_0P12))
            + $bitstoreal(C_MINUS2);
        p = eps * seventh_power(a);
        p = p * b;
        return p;
    endfunction

    assign pending = energy_queue.size();

    always @(posedge aclk) begin
        real r, e, total;
        logic [2:0] fl;
        energy_result_t exp_res;
        energy_result_t got;
        if (!aresetn) begin
            cutoff_bits <= C_POS_ZERO;
            running_sum = 0.0;
            energy_queue.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we)
                cutoff_bits <= cfg_wdata;

            // predict each accepted pair
            if (s_axis_tvalid && s_axis_tready) begin
                r  = $bitstoreal(s_axis_tdata[63:0]);
                fl = s_axis_tuser;
                if (fl[0]) begin
                    e = 0.0;
                    if (!((r > $bitstoreal(cutoff_bits)) || fl[1] || fl[2]))
                        e = e + buffered_14_7(r, $bitstoreal(s_axis_tdata[127:64]),
                                              $bitstoreal(s_axis_tdata[191:128]));
                end else begin
                    e = $bitstoreal(s_axis_tdata[255:192]);
                end
                total = running_sum + e;
                running_sum = s_axis_tlast ? 0.0 : total;
                exp_res.pair_energy  = $realtobits(e);
                exp_res.total_energy = $realtobits(total);
                exp_res.total_done   = s_axis_tlast;
                energy_queue.push_back(exp_res);
            end

            // compare each result beat with the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                got.pair_energy  = m_axis_tdata[63:0];
                got.total_energy = m_axis_tdata[127:64];
                got.total_done   = m_axis_tlast;
                if (energy_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result beat: pair %h total %h done %b",
                                 got.pair_energy, got.total_energy, got.total_done);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_res = energy_queue.pop_front();
                    if (got.pair_energy !== exp_res.pair_energy
                        || got.total_energy !== exp_res.total_energy
                        || got.total_done !== exp_res.total_done) begin
                        if (fail_count < 10)
                            $display("mismatch: pair %h/%h total %h/%h done %b/%b (exp/act)",
                                     exp_res.pair_energy, got.pair_energy,
                                     exp_res.total_energy, got.total_energy,
                                     exp_res.total_done, got.total_done);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[sim/tb_buffered_14_7_pair_energy_unit.sv]
module tb_buffered_14_7_pair_energy_unit;
    import bpe_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [63:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;    // distance, sigma_value, epsilon_value, stored_energy
    logic [2:0]   s_axis_tuser;    // recalculate, excluded, frozen_pair
    logic         s_axis_tlast;    // last_pair
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;    // pair_energy, total_energy
    logic         m_axis_tlast;    // total_done

    int fail_count;
    int pending;
    bit calm;
    bit hold_req;

    localparam logic [2:0] FL_RECALC = 3'b001;
    localparam logic [2:0] FL_EXCL   = 3'b010;
    localparam logic [2:0] FL_FROZEN = 3'b100;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    buffered_14_7_pair_energy_unit uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    pair_energy_checker energy_chk (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast), .fail_count(fail_count), .pending(pending)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // result side: random stalls, one long hold on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (1500) @(posedge aclk);
            end
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 34);
        end
    end

    initial begin
        #200_000_000;
        $display("buffered_14_7_pair_energy_unit test failed");
        $finish;
    end

    task automatic send_pair(input logic [63:0] r, input logic [63:0] s,
                             input logic [63:0] eps, input logic [63:0] stored,
                             input logic [2:0] flags, input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {stored, eps, s, r};
        s_axis_tuser  <= flags;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (!calm && $urandom_range(0, 99) < 34) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_cutoff(input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly physical pairs with random content, some raw-bit noise
    task automatic random_pairs(input int count);
        real sig, q;
        logic [63:0] r, s, eps, st;
        logic [2:0] fl;
        repeat (count) begin
            sig = 2.5 + $urandom_range(0, 2000) / 1000.0;
            q   = 0.5 + $urandom_range(0, 2500) / 1000.0;
            r   = $realtobits(sig * q);
            s   = $realtobits(sig);
            eps = $realtobits($urandom_range(1, 5000) / 10000.0);
            st  = $realtobits(-($urandom_range(0, 100000) / 1000.0));
            fl  = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 99) < 50)
                fl[2:1] = 2'b00;
            if ($urandom_range(0, 99) < 15) begin
                r = rand64(); s = rand64(); eps = rand64(); st = rand64();
            end
            send_pair(r, s, eps, st, fl, $urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset cutoff of +0: any positive distance is out of range
        random_pairs(60);
        wait_drained();

        write_cutoff($realtobits(10.0));
        send_pair($realtobits(3.5), $realtobits(3.5), $realtobits(0.1), '0,
                  FL_RECALC, 1'b0);
        send_pair($realtobits(12.0), $realtobits(3.5), $realtobits(0.1), '0,
                  FL_RECALC, 1'b0);
        send_pair($realtobits(4.0), $realtobits(3.5), $realtobits(0.1), '0,
                  FL_RECALC | FL_EXCL, 1'b0);
        send_pair($realtobits(4.0), $realtobits(3.5), $realtobits(0.1), '0,
                  FL_RECALC | FL_FROZEN, 1'b0);
        send_pair(ALL_ONES, '0, '0, 64'h8000_0000_0000_0000, FL_EXCL | FL_FROZEN, 1'b0);
        send_pair('0, '0, $realtobits(0.2), '0, FL_RECALC, 1'b0);
        send_pair($realtobits(1.0), '0, $realtobits(0.2), '0, FL_RECALC, 1'b0);
        send_pair($realtobits(1.0), 64'h8000_0000_0000_0000, $realtobits(0.2), '0,
                  FL_RECALC, 1'b1);
        send_pair(ALL_ONES, $realtobits(3.0), $realtobits(0.2), '0, FL_RECALC, 1'b0);
        send_pair($realtobits(-1.0), $realtobits(3.0), $realtobits(0.2), '0,
                  FL_RECALC, 1'b0);
        send_pair(64'h7FF0_0000_0000_0000, $realtobits(3.0), $realtobits(0.2), '0,
                  FL_RECALC, 1'b0);
        send_pair($realtobits(3.0), $realtobits(3.0), ALL_ONES, '0, FL_RECALC, 1'b0);
        send_pair($realtobits(3.0), $realtobits(3.0), 64'h8000_0000_0000_0000, '0,
                  FL_RECALC, 1'b1);
        send_pair($realtobits(0.001), $realtobits(1.0), $realtobits(0.3), '0,
                  FL_RECALC, 1'b0);
        send_pair(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, '0, 1'b1);
        send_pair('0, '0, '0, '0, '0, 1'b1);
        send_pair($realtobits(5.0), $realtobits(1.0e300), $realtobits(0.3), '0,
                  FL_RECALC, 1'b0);
        send_pair(64'h0000_0000_0000_0001, $realtobits(2.0), $realtobits(0.3), '0,
                  FL_RECALC, 1'b0);
        send_pair(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 3'b111, 1'b1);
        wait_drained();

        // receiver holds off while pairs keep coming
        hold_req = 1'b1;
        random_pairs(260);
        wait_drained();

        write_cutoff(ALL_ONES);
        calm = 1'b1;
        random_pairs(260);
        calm = 1'b0;
        wait_drained();

        write_cutoff(64'h7FF0_0000_0000_0000);
        random_pairs(250);
        wait_drained();

        write_cutoff(64'h8000_0000_0000_0000);
        random_pairs(250);
        wait_drained();

        write_cutoff($realtobits(4.0));
        random_pairs(260);
        wait_drained();

        write_cutoff($realtobits(1.0e-300));
        random_pairs(260);
        wait_drained();

        repeat (400) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("buffered_14_7_pair_energy_unit test passed");
        else
            $display("buffered_14_7_pair_energy_unit test failed");
        $finish;
    end

endmodule
